>>> design/rsw_pkg.sv
// ---------------------------------------------------------------------------
// rsw_pkg
// shared types and codes for the replay sequence window block
// ---------------------------------------------------------------------------
package rsw_pkg;

    localparam int SEQ_W = 32;

    localparam logic       CMD_CHECK = 1'b0;
    localparam logic       CMD_CLEAR = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OLD     = 3'd1;
    localparam logic [2:0] ST_SKIP    = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [7:0] MAX_SKIP_RESET = 8'd10;

    typedef struct packed {
        logic             command;
        logic [1:0]       slot;
        logic [SEQ_W-1:0] sequence_number;
    } req_item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] status;
    } rsp_item_t;

    // outcome of one window check
    typedef struct packed {
        logic       write;
        logic [2:0] status;
    } upd_res_t;

endpackage

>>> design/replay_sequence_window.sv
// ---------------------------------------------------------------------------
// replay_sequence_window
// per-slot anti-replay window: rejects old, far-ahead and repeated numbers
// ---------------------------------------------------------------------------
//  channel   signals                          direction
//  req       req_valid / req_stall / req      in   command, slot, sequence number
//  rsp       rsp_valid / rsp_stall / rsp      out  accepted, status
//  cfg       cfg_valid / cfg_ready / cfg_data in   max_skip write
//
//  a request is handled as the window row read from memory, then the
//  compare, insert and write back of the same row; one request at a time
//  the result waits in an output register; a new request is taken in the
//  cycle that result is taken, and is held off while the result is stalled
//  reset empties every slot (fill counts only) and sets max_skip to 10
//  cfg_ready is always high
// ---------------------------------------------------------------------------
module replay_sequence_window #(
    parameter int WINDOW = 20,
    parameter int SLOTS  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rsw_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsw_pkg::rsp_item_t rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import rsw_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic                    state_reg;
    logic                    state_next;
    logic [7:0]              max_skip_reg;
    logic [CW-1:0]           count_reg [SLOTS];
    logic [SW-1:0]           slot_reg;
    logic                    cmd_reg;
    logic [31:0]             seq_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_reg;

    logic                    take;
    logic [SW-1:0]           slot_idx;
    logic [WINDOW-1:0][31:0] rd_row;
    logic [WINDOW-1:0][31:0] new_row;
    logic [CW-1:0]           cur_count;
    logic [CW-1:0]           new_count;
    upd_res_t                upd;
    logic                    mem_wr;
    rsp_item_t               rsp_next;

    // slot taken modulo SLOTS
    always_comb
    begin
        logic [2:0] v;
        v = {1'b0, req.slot};
        for (int k = 0; k < 3; k++)
        begin
            if (int'(v) >= SLOTS)
            begin
                v = v - 3'(SLOTS);
            end
        end
        slot_idx = SW'(v);
    end

    assign take      = req_valid && !req_stall;
    assign req_stall = (state_reg == S_CALC) || (rsp_valid_reg && rsp_stall);
    assign cfg_ready = 1'b1;
    assign cur_count = count_reg[slot_reg];
    assign mem_wr    = (state_reg == S_CALC) && (cmd_reg == CMD_CHECK) && upd.write;

    rsw_window_mem #(
        .WINDOW (WINDOW),
        .SLOTS  (SLOTS),
        .SW     (SW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (slot_idx),
        .rd_data (rd_row),
        .wr_en   (mem_wr),
        .wr_addr (slot_reg),
        .wr_data (new_row)
    );

    rsw_update #(
        .WINDOW (WINDOW),
        .CW     (CW)
    ) u_update (
        .row       (rd_row),
        .count     (cur_count),
        .seq       (seq_reg),
        .max_skip  (max_skip_reg),
        .res       (upd),
        .new_row   (new_row),
        .new_count (new_count)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd_reg == CMD_CLEAR)
        begin
            rsp_next.accepted = 1'b1;
            rsp_next.status   = ST_CLEARED;
        end
        else
        begin
            rsp_next.accepted = upd.write;
            rsp_next.status   = upd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_skip_reg  <= MAX_SKIP_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                max_skip_reg <= cfg_data;
            end
            if (state_reg == S_CALC)
            begin
                rsp_valid_reg <= 1'b1;
                if (cmd_reg == CMD_CLEAR)
                begin
                    count_reg[slot_reg] <= '0;
                end
                else if (upd.write)
                begin
                    count_reg[slot_reg] <= new_count;
                end
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg <= slot_idx;
            cmd_reg  <= req.command;
            seq_reg  <= req.sequence_number;
        end
        if (state_reg == S_CALC)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_calc_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |=> state_reg == S_IDLE)
        else $error("calc state held longer than one cycle");

    a_rsp_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_CALC))
        else $error("result appeared without a calc cycle");

    a_calc_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |-> !rsp_valid_reg)
        else $error("output register still full when a result is produced");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |-> cur_count <= CW'(WINDOW))
        else $error("window fill count out of range");

    a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.accepted == ((rsp.status == ST_OK) || (rsp.status == ST_CLEARED))))
        else $error("accepted flag disagrees with status");

endmodule

>>> design/rsw_window_mem.sv
// ---------------------------------------------------------------------------
// rsw_window_mem
// one row per slot holding the whole sorted window, registered read
// ---------------------------------------------------------------------------
module rsw_window_mem #(
    parameter int WINDOW = 20,
    parameter int SLOTS  = 4,
    parameter int SW     = 2
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [SW-1:0]                rd_addr,
    output logic [WINDOW-1:0][31:0]      rd_data,
    input  logic                         wr_en,
    input  logic [SW-1:0]                wr_addr,
    input  logic [WINDOW-1:0][31:0]      wr_data
);

    logic [WINDOW-1:0][31:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/rsw_update.sv
// ---------------------------------------------------------------------------
// rsw_update
// parallel compare of all window cells and sorted insert of the new number
// ---------------------------------------------------------------------------
module rsw_update #(
    parameter int WINDOW = 20,
    parameter int CW     = 5
) (
    input  logic [WINDOW-1:0][31:0]  row,
    input  logic [CW-1:0]            count,
    input  logic [31:0]              seq,
    input  logic [7:0]               max_skip,
    output rsw_pkg::upd_res_t        res,
    output logic [WINDOW-1:0][31:0]  new_row,
    output logic [CW-1:0]            new_count
);
    import rsw_pkg::*;

    logic [WINDOW-1:0] valid;
    logic [WINDOW:0]   lt;
    logic [WINDOW-1:0] eq;
    logic [31:0]       lo;
    logic [31:0]       hi;
    logic [32:0]       sum;
    logic [31:0]       lim;
    logic              full;
    logic              empty;

    always_comb
    begin
        hi = '0;
        lt = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            valid[i] = (CW'(i) < count);
            lt[i]    = valid[i] && (row[i] < seq);
            eq[i]    = valid[i] && (row[i] == seq);
            if (CW'(i) + CW'(1) == count)
            begin
                hi = hi | row[i];
            end
        end
    end

    assign lo    = row[0];
    assign full  = (count == CW'(WINDOW));
    assign empty = (count == '0);
    assign sum   = {1'b0, hi} + {25'b0, max_skip};
    assign lim   = sum[32] ? 32'hffff_ffff : sum[31:0];

    always_comb
    begin
        res.write  = 1'b0;
        res.status = ST_OK;
        if (empty)
        begin
            if (seq > {24'b0, max_skip})
            begin
                res.status = ST_SKIP;
            end
        end
        else if (full && (seq < lo))
        begin
            res.status = ST_OLD;
        end
        else if (seq > lim)
        begin
            res.status = ST_SKIP;
        end
        else if (|eq)
        begin
            res.status = ST_DUP;
        end
        res.write = (res.status == ST_OK);
    end

    // lt is a prefix since the window is sorted, so its edge marks the insert point
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            if (full)
            begin
                // oldest entry drops out, everything below the insert point moves down
                if (lt[i+1])
                begin
                    new_row[i] = row[(i+1) % WINDOW];
                end
                else if (lt[i])
                begin
                    new_row[i] = seq;
                end
                else
                begin
                    new_row[i] = row[i];
                end
            end
            else
            begin
                if (lt[i])
                begin
                    new_row[i] = row[i];
                end
                else if ((i == 0) || lt[(i+WINDOW-1) % WINDOW])
                begin
                    new_row[i] = seq;
                end
                else
                begin
                    new_row[i] = row[(i+WINDOW-1) % WINDOW];
                end
            end
        end
    end

    assign new_count = full ? CW'(WINDOW) : count + CW'(1);

endmodule

>>> dv/replay_sequence_window_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// replay_sequence_window_test
// drives check and clear requests into the replay window block under random
// flow control, predicts every response from a shadow copy of the per-slot
// windows and compares accepted and status on each response
// ---------------------------------------------------------------------------
module replay_sequence_window_test;
    import rsw_pkg::*;

    localparam int WINDOW          = 20;
    localparam int SLOTS           = 4;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int SETTLE_CYCLES   = 6;

    class replay_window_scoreboard;

        logic [SEQ_W-1:0] rows [SLOTS][WINDOW];
        int unsigned      fill [SLOTS];
        logic [7:0]       max_skip;
        rsp_item_t        pending_verdicts [$];
        int unsigned      mismatches;

        function new();
            foreach (fill[i])
                fill[i] = 0;
            max_skip   = MAX_SKIP_RESET;
            mismatches = 0;
        endfunction

        // applies one request to the shadow windows and returns its response
        function rsp_item_t window_verdict(req_item_t r);
            rsp_item_t        v;
            int unsigned      s;
            int unsigned      n;
            int unsigned      p;
            logic [SEQ_W:0]   limit;
            logic [SEQ_W-1:0] seq;
            logic [SEQ_W-1:0] merged [$];
            s          = r.slot % SLOTS;
            n          = fill[s];
            seq        = r.sequence_number;
            v.accepted = 1'b1;
            v.status   = ST_OK;
            if (r.command == CMD_CLEAR)
            begin
                fill[s]  = 0;
                v.status = ST_CLEARED;
                return v;
            end
            if (n > 0)
            begin
                // newest + max_skip saturates at the top of the sequence range
                limit = {1'b0, rows[s][n-1]} + max_skip;
                if (limit[SEQ_W])
                    limit = {1'b0, {SEQ_W{1'b1}}};
                if (seq < rows[s][0] && n >= WINDOW)
                    v.status = ST_OLD;
                else if ({1'b0, seq} > limit)
                    v.status = ST_SKIP;
            end
            else if (seq > max_skip)
            begin
                v.status = ST_SKIP;
            end
            if (v.status == ST_OK)
            begin
                p = 0;
                while (p < n && rows[s][p] < seq)
                    p++;
                if (p < n && rows[s][p] == seq)
                begin
                    v.status = ST_DUP;
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                        merged = {merged, rows[s][i]};
                    merged.insert(p, seq);
                    // overflow drops the oldest entry
                    if (merged.size() > WINDOW)
                        void'(merged.pop_front());
                    foreach (merged[i])
                        rows[s][i] = merged[i];
                    fill[s] = merged.size();
                end
            end
            v.accepted = (v.status == ST_OK);
            return v;
        endfunction

        function void note_request(req_item_t r);
            pending_verdicts = {pending_verdicts, window_verdict(r)};
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("response with no request outstanding: accepted %0d status %0d",
                       got.accepted, got.status);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted)
            begin
                $error("accepted mismatch: expected %0d actual %0d", want.accepted,
                       got.accepted);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction

    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_item_t  req       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_item_t  rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    bit sender_quiet = 1'b0;

    replay_window_scoreboard sb;

    replay_sequence_window u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // response back-pressure: quiet stretches, short stalls and a few long ones
    initial
    begin
        int pick;
        int len;
        logic level;
        forever
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                len   = $urandom_range(20, 60);
                level = 1'b0;
            end
            else if (pick < 65)
            begin
                len   = 1;
                level = 1'b0;
            end
            else if (pick < 95)
            begin
                len   = $urandom_range(1, 3);
                level = 1'b1;
            end
            else
            begin
                len   = $urandom_range(10, 40);
                level = 1'b1;
            end
            repeat (len)
                @(negedge clk) rsp_stall = level;
        end
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_quiet || pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic req_item_t make_request(logic cmd, logic [1:0] slot,
                                               logic [SEQ_W-1:0] seq);
        req_item_t r;
        r.command         = cmd;
        r.slot            = slot;
        r.sequence_number = seq;
        return r;
    endfunction

    // mostly numbers aimed at the slot's current window, some pure noise and a few clears
    function automatic req_item_t next_request();
        req_item_t        r;
        int unsigned      n;
        int               pick;
        int               skip;
        logic [SEQ_W-1:0] newest;
        logic [SEQ_W-1:0] oldest;
        r    = make_request(CMD_CHECK, 2'($urandom_range(0, 3)), $urandom);
        n    = sb.fill[r.slot];
        skip = int'(sb.max_skip);
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            r.command = CMD_CLEAR;
        end
        else if (pick < 9)
        begin
            // keep the random number as it is
        end
        else if (n == 0)
        begin
            r.sequence_number = $urandom_range(0, skip + 3);
        end
        else
        begin
            newest = sb.rows[r.slot][n-1];
            oldest = sb.rows[r.slot][0];
            pick   = $urandom_range(0, 99);
            if (pick < 55)
                r.sequence_number = newest + $urandom_range(1, skip + 2);
            else if (pick < 70)
                r.sequence_number = sb.rows[r.slot][$urandom_range(0, n - 1)];
            else if (pick < 85)
                r.sequence_number = oldest - $urandom_range(0, 3);
            else
                r.sequence_number = newest - $urandom_range(0, 30);
        end
        return r;
    endfunction

    task automatic send_request(input req_item_t item);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        req_valid = 1'b1;
        req       = item;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
    endtask

    task automatic settle_block();
        @(negedge clk) req_valid = 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_max_skip(input logic [7:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.max_skip = value;
        @(negedge clk) cfg_valid = 1'b0;
    endtask

    initial
    begin
        logic [7:0] skip_plan [8];
        sb        = new();
        skip_plan = '{8'd255, 8'd1, 8'd37, 8'd0, 8'd10, 8'd200, 8'd3, 8'($urandom)};
        repeat (12)
            @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // reset max_skip of 10: empty windows, duplicates, front insert, skips
        send_request(make_request(CMD_CHECK, 2'd0, 32'd0));
        send_request(make_request(CMD_CHECK, 2'd0, 32'd0));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd11));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd10));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd3));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd21));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd20));
        send_request(make_request(CMD_CHECK, 2'd1, 32'hFFFF_FFFF));
        send_request(make_request(CMD_CHECK, 2'd2, 32'd0));
        send_request(make_request(CMD_CLEAR, 2'd1, 32'hFFFF_FFFF));
        send_request(make_request(CMD_CHECK, 2'd1, 32'd10));
        send_request(make_request(CMD_CHECK, 2'd2, 32'd11));
        settle_block();

        // zero skip: no number above the newest entry, or above 0 in an empty slot, gets through
        set_max_skip(8'd0);
        send_request(make_request(CMD_CHECK, 2'd0, 32'd1));
        send_request(make_request(CMD_CHECK, 2'd3, 32'd0));
        send_request(make_request(CMD_CHECK, 2'd3, 32'd1));
        send_request(make_request(CMD_CHECK, 2'd0, 32'd0));
        settle_block();

        set_max_skip(8'd255);
        send_request(make_request(CMD_CHECK, 2'd0, 32'd255));
        send_request(make_request(CMD_CHECK, 2'd0, 32'd511));
        send_request(make_request(CMD_CHECK, 2'd0, 32'd510));
        send_request(make_request(CMD_CHECK, 2'd0, 32'd128));
        send_request(make_request(CMD_CLEAR, 2'd3, 32'd0));

        foreach (skip_plan[ph])
        begin
            // sender holds off until every response is back
            settle_block();
            set_max_skip(skip_plan[ph]);
            sender_quiet = (ph % 3 == 2);
            repeat (ITEMS_PER_PHASE)
                send_request(next_request());
        end

        settle_block();
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/rsw_pkg.sv
design/rsw_window_mem.sv
design/rsw_update.sv
design/replay_sequence_window.sv
dv/replay_sequence_window_test.sv
